@@ hw/rtl/rur_pkg.sv @@
// ----------------------------------------------------------------------------
// rur_pkg
// Shared types and constants of the reliable datagram receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rur_pkg;

   localparam int WINDOW     = 16;
   localparam int WIN_IDX_W  = $clog2(WINDOW);
   localparam int SEQ_W      = 32;
   localparam int REF_W      = 16;
   localparam int TICK_W     = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TICK_W-1:0] ACK_DELAY_RESET   = TICK_W'(10);
   localparam logic [TICK_W-1:0] FIN_TIMEOUT_RESET = TICK_W'(2000);

   localparam logic [0:0] REG_ACK_DELAY   = 1'b0;
   localparam logic [0:0] REG_FIN_TIMEOUT = 1'b1;

   localparam logic [1:0] CMD_PACKET = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_LISTEN = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [2:0] KIND_DELIVER   = 3'd0;
   localparam logic [2:0] KIND_ACK       = 3'd1;
   localparam logic [2:0] KIND_SYN_ACK   = 3'd2;
   localparam logic [2:0] KIND_FIN_ACK   = 3'd3;
   localparam logic [2:0] KIND_CLOSED_OK = 3'd4;
   localparam logic [2:0] KIND_CLOSED_TO = 3'd5;

   typedef enum logic [2:0] {
      CONN_CLOSED,
      CONN_LISTEN,
      CONN_SYN_RCVD,
      CONN_ESTABLISHED,
      CONN_FIN_RCVD
   } conn_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_EXEC,
      PH_DRAIN
   } phase_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic             checksum_ok;
      logic             flag_syn;
      logic             flag_ack;
      logic             flag_fin;
      logic [SEQ_W-1:0] conn_id;
      logic [SEQ_W-1:0] seq;
      logic [REF_W-1:0] payload_ref;
   } req_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [SEQ_W-1:0] hdr_conn_id;
      logic [SEQ_W-1:0] hdr_seq;
      logic [SEQ_W-1:0] hdr_ack;
      logic [SEQ_W-1:0] deliver_seq;
      logic [REF_W-1:0] deliver_ref;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic                 clear_all;
      logic                 set_en;
      logic [WIN_IDX_W-1:0] set_idx;
      logic [REF_W-1:0]     set_ref;
      logic                 clr_en;
      logic [WIN_IDX_W-1:0] clr_idx;
      logic [WIN_IDX_W-1:0] rd_idx;
   } win_ctl_type;

   function automatic logic [WIN_IDX_W-1:0] idx_inc(input logic [WIN_IDX_W-1:0] idx);
      logic [WIN_IDX_W-1:0] res;
      if (idx == WIN_IDX_W'(WINDOW - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/rur_window.sv @@
// ----------------------------------------------------------------------------
// rur_window
// Reorder window: valid flags in flops, payload handles in a synchronous RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rur_window
   import rur_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  win_ctl_type             ctl,
   output logic [WINDOW-1:0]       valid,
   output logic [REF_W-1:0]        rd_ref
);

   logic [WINDOW-1:0] valid_ff;
   logic [WINDOW-1:0] valid_in;
   logic [REF_W-1:0]  mem [WINDOW];
   logic [REF_W-1:0]  rd_ref_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else begin
         if (ctl.set_en) begin
            valid_in[ctl.set_idx] = 1'b1;
         end
         if (ctl.clr_en) begin
            valid_in[ctl.clr_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.set_en) begin
         mem[ctl.set_idx] <= ctl.set_ref;
      end
      rd_ref_ff <= mem[ctl.rd_idx];
   end

   assign valid  = valid_ff;
   assign rd_ref = rd_ref_ff;

endmodule

@@ hw/rtl/reliable_udp_receiver.sv @@
// ----------------------------------------------------------------------------
// reliable_udp_receiver
// Receive side of a reliable datagram link with a reorder window.
// ----------------------------------------------------------------------------
// An item (packet header, tick or listen command) is taken at a clock edge
// where start is high and busy is low. Results come out on rsp_data, one per
// cycle, each marked by rsp_valid for exactly one cycle; the last result of an
// item has rsp_data.last set. The receiver cannot stall the results.
// An item is evaluated in the cycle after it is taken, and its first result
// appears in the cycle after that. An item with one result or none keeps busy
// high only while it is evaluated. An in-order packet that releases k
// buffered packets delivers them one per cycle from the window RAM. The
// window RAM read of the next slot sets that drain rate.
// busy is high from the edge that takes an item until its last result is
// shown. Configuration registers sit on the csr_ APB port at byte addresses
// 0 (ACK delay) and 4 (FIN timeout). Reset returns the link to closed, clears
// the window flags and counters, and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reliable_udp_receiver
   import rur_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   phase_type             phase_ff, phase_in;
   conn_state_type        conn_ff, conn_in;
   req_type               req_ff;
   logic [SEQ_W-1:0]      local_seq_ff, local_seq_in;
   logic [SEQ_W-1:0]      exp_seq_ff, exp_seq_in;
   logic [SEQ_W-1:0]      peer_ff, peer_in;
   logic [SEQ_W-1:0]      fin_seq_ff, fin_seq_in;
   logic                  ack_pend_ff, ack_pend_in;
   logic [TICK_W-1:0]     ack_tmr_ff, ack_tmr_in;
   logic [TICK_W-1:0]     fin_tmr_ff, fin_tmr_in;
   logic [WIN_IDX_W-1:0]  head_ff, head_in;
   logic [TICK_W-1:0]     ack_wait_ff;
   logic [TICK_W-1:0]     fin_to_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  drain_go;

   win_ctl_type           win_ctl;
   logic [WINDOW-1:0]     win_valid;
   logic [REF_W-1:0]      win_ref;

   logic                  accept;
   logic                  good;
   logic [WIN_IDX_W-1:0]  head_nxt;
   logic [SEQ_W-1:0]      seq_p1;
   logic [SEQ_W-1:0]      off;
   logic [WIN_IDX_W:0]    slot_sum;
   logic [WIN_IDX_W-1:0]  slot_idx;
   logic                  csr_wr;

   rur_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .valid  (win_valid),
      .rd_ref (win_ref)
   );

   assign accept   = start && (phase_ff == PH_IDLE);
   assign good     = req_ff.checksum_ok && (req_ff.conn_id == peer_ff);
   assign head_nxt = idx_inc(head_ff);
   assign seq_p1   = req_ff.seq + 1'b1;
   assign off      = req_ff.seq - exp_seq_ff;
   assign slot_sum = {1'b0, head_ff} + {1'b0, off[WIN_IDX_W-1:0]};

   // Head plus offset stays below twice the window, so one subtract wraps it.
   always_comb begin
      if (slot_sum >= (WIN_IDX_W+1)'(WINDOW)) begin
         slot_idx = WIN_IDX_W'(slot_sum - (WIN_IDX_W+1)'(WINDOW));
      end else begin
         slot_idx = slot_sum[WIN_IDX_W-1:0];
      end
   end

   // Phase sequencing.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_EXEC;
            end
         end
         PH_EXEC, PH_DRAIN: begin
            phase_in = drain_go ? PH_DRAIN : PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Link state update and result formation.
   always_comb begin
      conn_in      = conn_ff;
      local_seq_in = local_seq_ff;
      exp_seq_in   = exp_seq_ff;
      peer_in      = peer_ff;
      fin_seq_in   = fin_seq_ff;
      ack_pend_in  = ack_pend_ff;
      ack_tmr_in   = ack_tmr_ff;
      fin_tmr_in   = fin_tmr_ff;
      head_in      = head_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      drain_go     = 1'b0;
      win_ctl         = '0;
      win_ctl.set_idx = slot_idx;
      win_ctl.set_ref = req_ff.payload_ref;
      win_ctl.clr_idx = head_ff;
      win_ctl.rd_idx  = head_nxt;

      if (phase_ff == PH_DRAIN) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = KIND_DELIVER;
         rsp_in.deliver_seq = exp_seq_ff;
         rsp_in.deliver_ref = win_ref;
         rsp_in.last        = !win_valid[head_nxt];
         win_ctl.clr_en     = 1'b1;
         exp_seq_in         = exp_seq_ff + 1'b1;
         head_in            = head_nxt;
         drain_go           = win_valid[head_nxt];
      end else if (phase_ff == PH_EXEC) begin
         priority if (req_ff.cmd == CMD_LISTEN) begin
            if (conn_ff == CONN_CLOSED) begin
               conn_in = CONN_LISTEN;
            end
         end else if (req_ff.cmd == CMD_TICK) begin
            if (conn_ff == CONN_ESTABLISHED && ack_pend_ff) begin
               if (ack_tmr_ff <= TICK_W'(1)) begin
                  ack_pend_in        = 1'b0;
                  ack_tmr_in         = '0;
                  rsp_valid_in       = 1'b1;
                  rsp_in.kind        = KIND_ACK;
                  rsp_in.hdr_conn_id = peer_ff;
                  rsp_in.hdr_seq     = local_seq_ff;
                  rsp_in.hdr_ack     = exp_seq_ff;
                  local_seq_in       = local_seq_ff + 1'b1;
               end else begin
                  ack_tmr_in = ack_tmr_ff - 1'b1;
               end
            end else if (conn_ff == CONN_FIN_RCVD) begin
               if (fin_tmr_ff <= TICK_W'(1)) begin
                  fin_tmr_in   = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = KIND_CLOSED_TO;
                  conn_in      = CONN_CLOSED;
               end else begin
                  fin_tmr_in = fin_tmr_ff - 1'b1;
               end
            end
         end else if (req_ff.cmd == CMD_PACKET) begin
            unique case (conn_ff)
               CONN_LISTEN: begin
                  if (req_ff.checksum_ok && req_ff.flag_syn && !req_ff.flag_ack) begin
                     peer_in            = req_ff.conn_id;
                     rsp_valid_in       = 1'b1;
                     rsp_in.kind        = KIND_SYN_ACK;
                     rsp_in.hdr_conn_id = req_ff.conn_id;
                     rsp_in.hdr_seq     = local_seq_ff;
                     rsp_in.hdr_ack     = seq_p1;
                     local_seq_in       = local_seq_ff + 1'b1;
                     conn_in            = CONN_SYN_RCVD;
                  end
               end
               CONN_SYN_RCVD: begin
                  if (good && req_ff.flag_ack) begin
                     exp_seq_in         = seq_p1;
                     rsp_valid_in       = 1'b1;
                     rsp_in.kind        = KIND_ACK;
                     rsp_in.hdr_conn_id = peer_ff;
                     rsp_in.hdr_seq     = local_seq_ff;
                     rsp_in.hdr_ack     = seq_p1;
                     local_seq_in       = local_seq_ff + 1'b1;
                     win_ctl.clear_all  = 1'b1;
                     head_in            = '0;
                     ack_pend_in        = 1'b0;
                     ack_tmr_in         = '0;
                     conn_in            = CONN_ESTABLISHED;
                  end
               end
               CONN_ESTABLISHED: begin
                  if (good) begin
                     priority if (req_ff.flag_fin) begin
                        exp_seq_in         = seq_p1;
                        ack_pend_in        = 1'b0;
                        ack_tmr_in         = '0;
                        fin_seq_in         = local_seq_ff;
                        rsp_valid_in       = 1'b1;
                        rsp_in.kind        = KIND_FIN_ACK;
                        rsp_in.hdr_conn_id = peer_ff;
                        rsp_in.hdr_seq     = local_seq_ff;
                        rsp_in.hdr_ack     = seq_p1;
                        local_seq_in       = local_seq_ff + 1'b1;
                        fin_tmr_in         = fin_to_ff;
                        conn_in            = CONN_FIN_RCVD;
                     end else if (req_ff.seq == exp_seq_ff) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.kind        = KIND_DELIVER;
                        rsp_in.deliver_seq = req_ff.seq;
                        rsp_in.deliver_ref = req_ff.payload_ref;
                        rsp_in.last        = !win_valid[head_nxt];
                        win_ctl.clr_en     = 1'b1;
                        exp_seq_in         = exp_seq_ff + 1'b1;
                        head_in            = head_nxt;
                        drain_go           = win_valid[head_nxt];
                        if (!ack_pend_ff) begin
                           ack_pend_in = 1'b1;
                           ack_tmr_in  = ack_wait_ff;
                        end
                     end else begin
                        // Old packets and future ones both get an immediate ACK;
                        // only future ones inside the window are kept.
                        if (req_ff.seq > exp_seq_ff && off < SEQ_W'(WINDOW)
                            && !win_valid[slot_idx]) begin
                           win_ctl.set_en = 1'b1;
                        end
                        ack_pend_in        = 1'b0;
                        rsp_valid_in       = 1'b1;
                        rsp_in.kind        = KIND_ACK;
                        rsp_in.hdr_conn_id = peer_ff;
                        rsp_in.hdr_seq     = local_seq_ff;
                        rsp_in.hdr_ack     = exp_seq_ff;
                        local_seq_in       = local_seq_ff + 1'b1;
                     end
                  end
               end
               CONN_FIN_RCVD: begin
                  rsp_valid_in = 1'b1;
                  if (good && req_ff.flag_ack && !req_ff.flag_fin) begin
                     rsp_in.kind = KIND_CLOSED_OK;
                     conn_in     = CONN_CLOSED;
                  end else begin
                     rsp_in.kind        = KIND_FIN_ACK;
                     rsp_in.hdr_conn_id = peer_ff;
                     rsp_in.hdr_seq     = fin_seq_ff;
                     rsp_in.hdr_ack     = exp_seq_ff;
                  end
               end
               default: begin
               end
            endcase
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         conn_ff      <= CONN_CLOSED;
         local_seq_ff <= '0;
         exp_seq_ff   <= '0;
         peer_ff      <= '0;
         fin_seq_ff   <= '0;
         ack_pend_ff  <= 1'b0;
         ack_tmr_ff   <= '0;
         fin_tmr_ff   <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         conn_ff      <= conn_in;
         local_seq_ff <= local_seq_in;
         exp_seq_ff   <= exp_seq_in;
         peer_ff      <= peer_in;
         fin_seq_ff   <= fin_seq_in;
         ack_pend_ff  <= ack_pend_in;
         ack_tmr_ff   <= ack_tmr_in;
         fin_tmr_ff   <= fin_tmr_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_wait_ff <= ACK_DELAY_RESET;
         fin_to_ff   <= FIN_TIMEOUT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_ACK_DELAY) begin
            ack_wait_ff <= csr_pwdata[TICK_W-1:0];
         end else begin
            fin_to_ff <= csr_pwdata[TICK_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FIN_TIMEOUT) ? {16'd0, fin_to_ff}
                                                         : {16'd0, ack_wait_ff};
   assign csr_pready = 1'b1;
   assign busy       = (phase_ff != PH_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ hw/rtl/rur_checker.sv @@
// ----------------------------------------------------------------------------
// rur_checker
// Port-level checks of the receiver's command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rur_checker
   import rur_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    csr_pready
);

   // A taken item keeps the block busy in the next cycle.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an item was taken");

   // A burst of deliveries has no gaps until its last beat.
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("result burst broke before its last beat");

   // The last beat of an item is followed by a free cycle.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result followed the last beat directly");

   // A non-final beat means the block is still working on the item.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("block idle while results remain");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port inserted a wait state");

endmodule

bind reliable_udp_receiver rur_checker u_rur_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

@@ tb/tb_checker.sv @@
// ----------------------------------------------------------------------------
// tb_checker
// Watches the request and result channels of the datagram receiver, predicts
// the headers, deliveries and close notices that each accepted item causes
// and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checker
   import rur_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int QDEPTH    = 64;
   localparam int STAGE_MAX = 20;

   logic [TICK_W-1:0] ack_wait;
   logic [TICK_W-1:0] fin_timeout;
   conn_state_type    link;
   logic [SEQ_W-1:0]  my_seq;
   logic [SEQ_W-1:0]  next_seq;
   logic [SEQ_W-1:0]  peer_id;
   logic [WINDOW-1:0] held;
   logic [REF_W-1:0]  held_ref [WINDOW];
   logic              ack_armed;
   logic [TICK_W-1:0] ack_count;
   logic [TICK_W-1:0] fin_count;
   logic [SEQ_W-1:0]  fin_seq;
   logic [WIN_IDX_W-1:0] head;

   // Predicted beats wait in a ring until the block shows them.
   rsp_type exp_ring [QDEPTH];
   int      exp_rd;
   int      exp_wr;
   int      exp_cnt;
   rsp_type stage [STAGE_MAX];
   int      stage_n;

   assign pending_count = exp_cnt;

   function automatic rsp_type mk(logic [2:0] k, logic [SEQ_W-1:0] c, logic [SEQ_W-1:0] s,
                                  logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] ds,
                                  logic [REF_W-1:0] dr);
      rsp_type r;
      r.kind = k; r.hdr_conn_id = c; r.hdr_seq = s; r.hdr_ack = a;
      r.deliver_seq = ds; r.deliver_ref = dr; r.last = 1'b0;
      return r;
   endfunction

   task automatic stage_add(rsp_type r);
      stage[stage_n] = r;
      stage_n = stage_n + 1;
   endtask

   task automatic send_header(logic [2:0] k, logic [SEQ_W-1:0] a);
      stage_add(mk(k, peer_id, my_seq, a, '0, '0));
      my_seq = my_seq + 1'b1;
   endtask

   task automatic step_one(req_type r);
      logic good;
      logic [SEQ_W-1:0] off;
      logic [WIN_IDX_W-1:0] s;
      int i;
      stage_n = 0;
      good = r.checksum_ok && (r.conn_id == peer_id);
      if (r.cmd == CMD_PACKET) begin
         case (link)
            CONN_LISTEN: if (r.checksum_ok && r.flag_syn && !r.flag_ack) begin
               peer_id = r.conn_id;
               send_header(KIND_SYN_ACK, r.seq + 1'b1);
               link = CONN_SYN_RCVD;
            end
            CONN_SYN_RCVD: if (good && r.flag_ack) begin
               next_seq = r.seq + 1'b1;
               send_header(KIND_ACK, r.seq + 1'b1);
               held = '0; head = '0;
               ack_armed = 1'b0; ack_count = '0;
               link = CONN_ESTABLISHED;
            end
            CONN_ESTABLISHED: if (good) begin
               if (r.flag_fin) begin
                  next_seq = r.seq + 1'b1;
                  ack_armed = 1'b0; ack_count = '0;
                  fin_seq = my_seq;
                  send_header(KIND_FIN_ACK, next_seq);
                  fin_count = fin_timeout;
                  link = CONN_FIN_RCVD;
               end else if (r.seq < next_seq) begin
                  ack_armed = 1'b0;
                  send_header(KIND_ACK, next_seq);
               end else if (r.seq == next_seq) begin
                  stage_add(mk(KIND_DELIVER, '0, '0, '0, r.seq, r.payload_ref));
                  held[head] = 1'b0; next_seq = next_seq + 1'b1; head = head + 1'b1;
                  while (held[head]) begin
                     stage_add(mk(KIND_DELIVER, '0, '0, '0, next_seq, held_ref[head]));
                     held[head] = 1'b0; next_seq = next_seq + 1'b1; head = head + 1'b1;
                  end
                  if (!ack_armed) begin
                     ack_armed = 1'b1; ack_count = ack_wait;
                  end
               end else begin
                  off = r.seq - next_seq;
                  if (off < WINDOW) begin
                     s = head + off[WIN_IDX_W-1:0];
                     if (!held[s]) begin
                        held[s] = 1'b1; held_ref[s] = r.payload_ref;
                     end
                  end
                  ack_armed = 1'b0;
                  send_header(KIND_ACK, next_seq);
               end
            end
            CONN_FIN_RCVD: if (good && r.flag_ack && !r.flag_fin) begin
               stage_add(mk(KIND_CLOSED_OK, '0, '0, '0, '0, '0));
               link = CONN_CLOSED;
            end else begin
               stage_add(mk(KIND_FIN_ACK, peer_id, fin_seq, next_seq, '0, '0));
            end
            default: ;
         endcase
      end else if (r.cmd == CMD_TICK) begin
         if (link == CONN_ESTABLISHED && ack_armed) begin
            if (ack_count <= 1) begin
               ack_armed = 1'b0; ack_count = '0;
               send_header(KIND_ACK, next_seq);
            end else ack_count = ack_count - 1'b1;
         end else if (link == CONN_FIN_RCVD) begin
            if (fin_count <= 1) begin
               fin_count = '0;
               stage_add(mk(KIND_CLOSED_TO, '0, '0, '0, '0, '0));
               link = CONN_CLOSED;
            end else fin_count = fin_count - 1'b1;
         end
      end else if (r.cmd == CMD_LISTEN && link == CONN_CLOSED) begin
         link = CONN_LISTEN;
      end
      if (stage_n > 0) stage[stage_n-1].last = 1'b1;
      for (i = 0; i < stage_n; i++) begin
         exp_ring[exp_wr] = stage[i];
         exp_wr = (exp_wr + 1) % QDEPTH;
         exp_cnt = exp_cnt + 1;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         ack_wait <= ACK_DELAY_RESET; fin_timeout <= FIN_TIMEOUT_RESET;
         link = CONN_CLOSED; my_seq = '0; next_seq = '0; peer_id = '0;
         held = '0; head = '0; ack_armed = 1'b0; ack_count = '0;
         fin_count = '0; fin_seq = '0;
         exp_rd = 0; exp_wr = 0; exp_cnt = 0;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == REG_ACK_DELAY) ack_wait <= csr_pwdata[15:0];
            else if (csr_paddr[CSR_ADDR_W-1:2] == REG_FIN_TIMEOUT)
               fin_timeout <= csr_pwdata[15:0];
         end
         // Results of an earlier item come out before a new one is taken.
         if (rsp_valid) begin
            if (exp_cnt == 0) begin
               if (fail_count < 10) $display("unexpected result beat %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = exp_ring[exp_rd];
               exp_rd = (exp_rd + 1) % QDEPTH;
               exp_cnt = exp_cnt - 1;
               if (e !== rsp_data) begin
                  if (fail_count < 10) $display("mismatch: expected %p actual %p", e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) step_one(req_data);
      end
   end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the datagram receiver: register settings, handshakes, data
// transfer with reordering and duplicates, teardown and noise, then verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import rur_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;
   int fail_count, pending_count;
   int idle_cycles = 0;
   logic [SEQ_W-1:0] cid, base;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   reliable_udp_receiver uut (.*);
   tb_checker chk (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   // The block stays busy in the cycle after an item is taken; start is dropped
   // once busy has fallen, before the next item is issued.
   task automatic issue(req_type r);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
      if ($urandom_range(0, 2) == 0) gap();
   endtask

   task automatic pkt(int ck, int s, int a, int f, logic [31:0] c, logic [31:0] q,
                      int pr);
      req_type r;
      r.cmd = CMD_PACKET; r.checksum_ok = ck[0]; r.flag_syn = s[0]; r.flag_ack = a[0];
      r.flag_fin = f[0]; r.conn_id = c; r.seq = q; r.payload_ref = pr[15:0];
      issue(r);
   endtask

   task automatic cmd_only(logic [1:0] c);
      req_type r;
      r = req_type'({22'($urandom), $urandom, $urandom});
      r.cmd = c;
      issue(r);
   endtask

   task automatic quiesce();
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [15:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'($urandom_range(0, 65535)), v}; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Opens a link: listen, SYN, then the handshake ACK that sets base.
   task automatic open_link(logic [31:0] c, logic [31:0] isn);
      cmd_only(CMD_LISTEN);
      pkt(1, 1, 0, $urandom_range(0, 1), c, isn, $urandom);
      pkt(1, $urandom_range(0, 1), 1, 0, c, isn, $urandom);
   endtask

   task automatic session(int n, logic [15:0] ad, logic [15:0] ft);
      int k;
      logic [31:0] off;
      quiesce();
      csr_write(REG_ACK_DELAY, ad);
      csr_write(REG_FIN_TIMEOUT, ft);
      cid = $urandom;
      base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : $urandom;
      open_link(cid, base);
      base = base + 1;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               pkt(1, 0, 0, 0, cid, base, $urandom);
               base = base + 1;
            end
            3, 4, 5: begin
               off = $urandom_range(1, 17);
               pkt(1, 0, $urandom_range(0, 1), 0, cid, base + off, $urandom);
            end
            6: pkt(1, 0, 0, 0, cid, base - $urandom_range(1, 3), $urandom);
            7: cmd_only(CMD_TICK);
            8: pkt($urandom_range(0, 1), $urandom, $urandom, 0,
                   ($urandom_range(0, 1) ? cid : $urandom), $urandom, $urandom);
            default: cmd_only(2'($urandom_range(0, 3)));
         endcase
      end
      pkt(1, 0, 1, 1, cid, base, $urandom);
      if ($urandom_range(0, 1)) pkt($urandom_range(0, 1), 0, 1, 1, cid, $urandom, 0);
      if ($urandom_range(0, 1)) pkt(1, 0, 1, 0, cid, $urandom, $urandom);
      else repeat (ft > 8 ? 3 : ft + 1) cmd_only(CMD_TICK);
      // Leave the link possibly half open.
      repeat (ft > 8 ? 0 : 2) cmd_only(CMD_TICK);
   endtask

   initial begin
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: ignored items while closed, handshake extremes, window edges.
      cmd_only(CMD_TICK);
      pkt(1, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 'hFFFF);
      cmd_only(CMD_NONE);
      cmd_only(CMD_LISTEN);
      pkt(0, 1, 0, 0, 0, 0, 0);
      pkt(1, 1, 1, 0, 0, 0, 0);
      pkt(1, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 'hFFFF);
      pkt(1, 0, 1, 0, 0, 5, 0);
      pkt(1, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      for (i = 15; i >= 1; i--) pkt(1, 0, 0, 0, 32'hFFFF_FFFF, i, 'h1000 + i);
      pkt(1, 0, 0, 0, 32'hFFFF_FFFF, 3, 'hDEAD);
      pkt(1, 0, 0, 0, 32'hFFFF_FFFF, 16, 0);
      pkt(1, 0, 0, 0, 32'hFFFF_FFFF, 0, 'hFFFF);
      cmd_only(CMD_TICK);
      pkt(1, 0, 0, 0, 32'hFFFF_FFFF, 2, 0);
      pkt(1, 0, 0, 1, 32'hFFFF_FFFF, 99, 0);
      pkt(0, 0, 1, 0, 32'hFFFF_FFFF, 0, 0);
      pkt(1, 0, 1, 0, 32'hFFFF_FFFF, 0, 0);
      // Sender holds off until every result has come.
      quiesce();
      session(40, 16'd1, 16'd1);
      session(40, 16'd65535, 16'd65535);
      session(50, 16'd2, 16'd3);
      session(40, 16'd0, 16'd0);
      session(40, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
      session(40, 16'($urandom_range(1, 65535)), 16'($urandom_range(2, 10)));
      // Force closed before the end by timeouts.
      repeat (12) cmd_only(CMD_TICK);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ reliable_udp_receiver.f @@
hw/rtl/rur_pkg.sv
hw/rtl/rur_window.sv
hw/rtl/reliable_udp_receiver.sv
hw/rtl/rur_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
